@@ rtl/plr_pkg.sv @@
package plr_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Shared divider: 32-bit dividend, rate-wide divisor
    localparam int DIV_W = 32;

    // Default cap on results per input sample
    localparam int MAX_BURST_DEF = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MULA,
        S_MULB,
        S_DIVS,
        S_DIVW,
        S_OUT,
        S_REMS,
        S_REMW
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [RATE_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quot;
        logic [RATE_W-1:0]  rem;
    } t_div_rsp;

endpackage

@@ rtl/plr_in_if.sv @@
interface plr_in_if;
    import plr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
    modport monitor (input valid, input in_sample, input ready);
endinterface

@@ rtl/plr_out_if.sv @@
interface plr_out_if;
    import plr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       last;
    logic                       burst_overflow;

    modport source (output valid, output out_sample, output last, output burst_overflow,
                    input ready);
    modport sink (input valid, input out_sample, input last, input burst_overflow,
                  output ready);
    modport monitor (input valid, input out_sample, input last, input burst_overflow,
                     input ready);
endinterface

@@ rtl/pcm_linear_resampler.sv @@
// Sequence: a priming input, a zero-rate input or one with the phase at or past the span
// gives no result and leaves the block ready. Otherwise a check state, then per result two
// multiply steps, a rounding step and the 32-step shared divider, plus the wait on the sink.
// A cut burst adds one remainder pass through the same divider.
// One input at a time: not ready until all results of it are transferred and any remainder pass ends.
// Reset (synchronous, active low): rates to 1, phase and previous sample to 0, unprimed.
module pcm_linear_resampler #(
    parameter int MAX_BURST = plr_pkg::MAX_BURST_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    plr_in_if.sink                         i_in_ch,
    plr_out_if.source                      o_out_ch,
    input  logic                           i_cfg_we,
    input  logic [plr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [plr_pkg::RATE_W-1:0]     i_cfg_data
);
    import plr_pkg::*;

    localparam int CNT_W = $clog2(MAX_BURST + 1);
    localparam int OVF_W = RATE_W + $clog2(MAX_BURST + 1) + 1;

    t_state r_state;
    t_state n_state;

    logic [RATE_W-1:0]          r_src;
    logic [RATE_W-1:0]          r_tgt;
    logic [RATE_W-1:0]          r_phase;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic                       r_primed;
    logic signed [SAMPLE_W-1:0] r_cur;
    logic [RATE_W-1:0]          r_p;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_ovf;
    logic signed [DIV_W-1:0]    r_prod;
    logic signed [DIV_W-1:0]    r_sum;
    logic                       r_neg;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_last;

    logic                       w_in_xfer;
    logic                       w_out_xfer;
    logic                       w_busy_item;
    logic [RATE_W-1:0]          w_wa;
    logic signed [2*RATE_W:0]   w_prod_a;
    logic signed [2*RATE_W:0]   w_prod_b;
    logic signed [DIV_W-1:0]    w_sum;
    logic [DIV_W-1:0]           w_mag;
    logic [RATE_W:0]            w_p_next;
    logic [OVF_W-1:0]           w_reach;
    logic [SAMPLE_W-1:0]        w_q;
    t_div_req                   w_req;
    t_div_rsp                   w_rsp;

    plr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_in_xfer  = i_in_ch.valid && i_in_ch.ready;
    assign w_out_xfer = o_out_ch.valid && o_out_ch.ready;

    // An accepted sample that produces results
    assign w_busy_item = r_primed && (r_src != '0) && (r_tgt != '0) && (r_phase < r_tgt);

    // Interpolation weights and products
    assign w_wa     = r_tgt - r_p;
    assign w_prod_a = r_prev * $signed({1'b0, w_wa});
    assign w_prod_b = r_cur * $signed({1'b0, r_p});
    assign w_sum    = r_prod + $signed(w_prod_b[DIV_W-1:0]);

    // Magnitude plus half the divisor: round half away from zero
    assign w_mag = (r_neg ? DIV_W'(-r_sum) : DIV_W'(r_sum))
                 + DIV_W'(r_tgt[RATE_W-1:1]);

    assign w_p_next = {1'b0, r_p} + {1'b0, r_src};
    assign w_reach  = OVF_W'(r_p) + OVF_W'(MAX_BURST) * OVF_W'(r_src);
    assign w_q      = w_rsp.quot[SAMPLE_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && w_busy_item) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = S_MULA;
            S_MULA:  n_state = S_MULB;
            S_MULB:  n_state = S_DIVS;
            S_DIVS:  n_state = S_DIVW;
            S_DIVW: begin
                if (w_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    if (!r_last) begin
                        n_state = S_MULA;
                    end else if (r_ovf) begin
                        n_state = S_REMS;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_REMS:  n_state = S_REMW;
            S_REMW: begin
                if (w_rsp.done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and divider requests
    always_comb begin
        i_in_ch.ready  = 1'b0;
        o_out_ch.valid = 1'b0;
        w_req.start    = 1'b0;
        w_req.dividend = w_mag;
        w_req.divisor  = r_tgt;
        unique case (r_state)
            S_IDLE: i_in_ch.ready = 1'b1;
            S_DIVS: w_req.start = 1'b1;
            S_OUT:  o_out_ch.valid = 1'b1;
            S_REMS: begin
                w_req.start    = 1'b1;
                w_req.dividend = DIV_W'(r_tgt - r_p);
                w_req.divisor  = r_src;
            end
            default: ;
        endcase
    end

    assign o_out_ch.out_sample     = r_out_sample;
    assign o_out_ch.last           = r_last;
    assign o_out_ch.burst_overflow = r_ovf;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= RATE_W'(1);
            r_tgt <= RATE_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SOURCE_RATE) begin
                r_src <= i_cfg_data;
            end else if (i_cfg_idx == CFG_TARGET_RATE) begin
                r_tgt <= i_cfg_data;
            end
        end
    end

    // Stream state: phase, previous sample, primed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_prev   <= '0;
            r_primed <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        if (!r_primed) begin
                            r_primed <= 1'b1;
                            r_prev   <= i_in_ch.in_sample;
                        end else if (r_src == '0 || r_tgt == '0) begin
                            r_prev <= i_in_ch.in_sample;
                        end else if (r_phase >= r_tgt) begin
                            r_phase <= r_phase - r_tgt;
                            r_prev  <= i_in_ch.in_sample;
                        end
                    end
                end
                S_OUT: begin
                    // Interval closed with every due result sent
                    if (w_out_xfer && r_last && !r_ovf) begin
                        r_phase <= RATE_W'(w_p_next - {1'b0, r_tgt});
                        r_prev  <= r_cur;
                    end
                end
                S_REMW: begin
                    // Cut burst: skip dropped results by the remainder
                    if (w_rsp.done) begin
                        r_phase <= (w_rsp.rem == '0) ? '0 : r_src - w_rsp.rem;
                        r_prev  <= r_cur;
                    end
                end
                default: ;
            endcase
        end
    end

    // Burst control: result count, overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_cnt <= '0;
                    end
                end
                S_CHECK: r_ovf <= w_reach < OVF_W'(r_tgt);
                S_OUT: begin
                    if (w_out_xfer) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_cur <= i_in_ch.in_sample;
                    r_p   <= r_phase;
                end
            end
            S_MULA: r_prod <= w_prod_a[DIV_W-1:0];
            S_MULB: begin
                // Capture the sum and its sign for the rounding step
                r_sum <= w_sum;
                r_neg <= w_sum[DIV_W-1];
            end
            S_DIVW: begin
                if (w_rsp.done) begin
                    r_out_sample <= r_neg ? $signed(SAMPLE_W'(-w_q)) : $signed(w_q);
                    r_last       <= (w_p_next >= {1'b0, r_tgt})
                                 || (r_cnt == CNT_W'(MAX_BURST - 1));
                end
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    r_p <= w_p_next[RATE_W-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/plr_divider.sv @@
module plr_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plr_pkg::t_div_req i_req,
    output plr_pkg::t_div_rsp o_rsp
);
    import plr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W-1:0]  r_quot;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_den;

    logic [RATE_W:0]   w_trial;
    logic              w_fit;
    logic [RATE_W:0]   w_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quot[DIV_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    // Control: run DIV_W steps, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath: quotient shifts in from the dividend register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_den  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIV_W-2:0], w_fit};
            r_rem  <= w_fit ? w_diff[RATE_W-1:0] : w_trial[RATE_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

@@ rtl/plr_checker.sv @@
module plr_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  logic i_out_last
);

    // Hold a pending result until it is transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before transfer");

    // Never take a sample while a result waits
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // A result never shows right after an input transfer
    a_in_then_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("result appeared in the cycle after an input transfer");

    // Stay busy after a result that is not the last of its burst
    a_burst_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_out_last) |=> !i_in_ready)
        else $error("input ready in the middle of a burst");

endmodule

bind pcm_linear_resampler plr_checker u_plr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_last  (o_out_ch.last)
);

@@ tb/plr_resample_checker.sv @@
module plr_resample_checker
    import plr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    plr_in_if.monitor             i_in_ch,
    plr_out_if.monitor            i_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [RATE_W-1:0]     i_cfg_data,
    output int                    o_fail_cnt,
    output int                    o_pending
);

    localparam int BURST_CAP    = MAX_BURST_DEF;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic signed [SAMPLE_W-1:0] smp;
        logic                       last;
        logic                       ovf;
    } resampled_t;

    // Shadow copy of the converter state
    logic [RATE_W-1:0]          src_rate;
    logic [RATE_W-1:0]          tgt_rate;
    logic [RATE_W-1:0]          phase;
    logic signed [SAMPLE_W-1:0] prev_smp;
    logic                       primed;
    resampled_t                 resampled_q[$];
    int                         mismatches = 0;

    // Blend two samples at phase p of span, round half away from zero, divide by span
    function automatic logic signed [SAMPLE_W-1:0] lerp_round(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [RATE_W-1:0]          p,
        input logic [RATE_W-1:0]          span
    );
        longint acc;
        longint half;
        acc  = longint'(a) * (longint'(span) - longint'(p)) + longint'(b) * longint'(p);
        half = longint'(span >> 1);
        if (acc >= 0) begin
            acc += half;
        end else begin
            acc -= half;
        end
        acc = acc / longint'(span);
        return acc[SAMPLE_W-1:0];
    endfunction

    // Queue the outputs one input sample causes and advance the shadow state
    function automatic void resample_input(input logic signed [SAMPLE_W-1:0] cur);
        int         due;
        int         emit;
        int         pos;
        resampled_t r;
        if (!primed) begin
            primed   = 1'b1;
            prev_smp = cur;
            return;
        end
        if (src_rate == '0 || tgt_rate == '0) begin
            prev_smp = cur;
            return;
        end
        pos = int'(phase);
        due = 0;
        if (pos < int'(tgt_rate)) begin
            due = (int'(tgt_rate) - pos + int'(src_rate) - 1) / int'(src_rate);
        end
        emit = (due > BURST_CAP) ? BURST_CAP : due;
        for (int k = 0; k < emit; k++) begin
            r.smp  = lerp_round(prev_smp, cur, pos[RATE_W-1:0], tgt_rate);
            r.last = (k + 1 == emit);
            r.ovf  = (due > BURST_CAP);
            resampled_q.push_back(r);
            pos += int'(src_rate);
        end
        // Dropped outputs still advance the phase
        pos      = int'(phase) + due * int'(src_rate) - int'(tgt_rate);
        phase    = pos[RATE_W-1:0];
        prev_smp = cur;
    endfunction

    always @(posedge i_clk) begin
        resampled_t want;
        if (!i_rst_n) begin
            src_rate = 16'd1;
            tgt_rate = 16'd1;
            phase    = '0;
            prev_smp = '0;
            primed   = 1'b0;
            resampled_q.delete();
        end else begin
            // Track register writes; spare indexes are ignored
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SOURCE_RATE) begin
                    src_rate = i_cfg_data;
                end else if (i_cfg_idx == CFG_TARGET_RATE) begin
                    tgt_rate = i_cfg_data;
                end
            end

            // Compare each output transfer with the oldest prediction
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (resampled_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected output: sample=%0d last=%0b ovf=%0b",
                                 $realtime, i_out_ch.out_sample, i_out_ch.last,
                                 i_out_ch.burst_overflow);
                    end
                end else begin
                    want = resampled_q.pop_front();
                    if (want.smp !== i_out_ch.out_sample || want.last !== i_out_ch.last ||
                        want.ovf !== i_out_ch.burst_overflow) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("[%0t] output mismatch: exp sample=%0d last=%0b ovf=%0b, got sample=%0d last=%0b ovf=%0b",
                                     $realtime, want.smp, want.last, want.ovf,
                                     i_out_ch.out_sample, i_out_ch.last,
                                     i_out_ch.burst_overflow);
                        end
                    end
                end
            end

            // Predict from each input transfer
            if (i_in_ch.valid && i_in_ch.ready) begin
                resample_input(i_in_ch.in_sample);
            end
        end
        o_fail_cnt <= mismatches;
        o_pending  <= resampled_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import plr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int SETTLE_CYCLES = 64;
    localparam int SEG_ITEMS     = 17;

    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_idx    = CFG_SOURCE_RATE;
    logic [RATE_W-1:0]          cfg_data   = '0;
    logic                       src_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0] src_sample = '0;
    logic                       sink_ready = 1'b0;
    int                         fail_cnt;
    int                         pending_cnt;
    int                         tx_gap_pct   = 6;
    int                         rx_stall_pct = 65;

    plr_in_if  in_ch ();
    plr_out_if out_ch ();

    assign in_ch.valid     = src_valid;
    assign in_ch.in_sample = src_sample;
    assign out_ch.ready    = sink_ready;

    pcm_linear_resampler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    plr_resample_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .i_out_ch   (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending_cnt)
    );

    always #5 i_clk = ~i_clk;

    // Stall the output side at random
    always @(posedge i_clk) begin
        sink_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Write one register, then return with the write enable low
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold off input until every predicted output has been transferred
    task automatic drain();
        src_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_rates(input logic [RATE_W-1:0] src, input logic [RATE_W-1:0] tgt);
        drain();
        cfg_write(CFG_SOURCE_RATE, src);
        cfg_write(CFG_TARGET_RATE, tgt);
    endtask

    // Offer one sample after a random gap and hold it until the transfer
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_gap_pct) gap++;
        if (gap > 0) begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_valid  <= 1'b1;
        src_sample <= smp;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Mostly random samples, with full-scale, zero and minus-one values now and then
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        if ($urandom_range(7) != 0) begin
            return SAMPLE_W'($urandom);
        end
        case ($urandom_range(3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    initial begin
        logic [RATE_W-1:0] src;
        logic [RATE_W-1:0] tgt;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unity rates out of reset; the first sample only primes
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        send_sample(16'sh0001);

        // Upsample by 64 across full-scale steps
        apply_rates(16'd1, 16'd64);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);

        // Far more outputs due than the burst cap
        apply_rates(16'd3, 16'hFFFF);
        send_sample(16'sh7FFF);

        // Largest rates at 1:1
        apply_rates(16'hFFFF, 16'hFFFF);
        send_sample(16'sh8000);

        // Leave the phase beyond a shrunken span, then walk it back
        apply_rates(16'd7, 16'd10);
        send_sample(16'sd100);
        drain();
        cfg_write(CFG_TARGET_RATE, 16'd2);
        send_sample(16'sd1234);
        send_sample(-16'sd4321);
        send_sample(16'sd77);

        // Zero rates give nothing but still track the sample
        apply_rates(16'd0, 16'd10);
        send_sample(-16'sd7);
        apply_rates(16'd5, 16'd0);
        send_sample(16'sd9);

        // Spare register indexes must not disturb the rates
        apply_rates(16'd2, 16'd5);
        cfg_write(CFG_SPARE_2, 16'h0000);
        cfg_write(CFG_SPARE_3, 16'hFFFF);
        send_sample(16'sh4000);
        send_sample(-16'sh4000);

        // Random streams under three idle profiles
        for (int ph = 0; ph < 3; ph++) begin
            tx_gap_pct   = (ph == 0) ? 6 : (ph == 1) ? 65 : 0;
            rx_stall_pct = (ph == 0) ? 65 : (ph == 1) ? 6 : 0;
            for (int seg = 0; seg < 3; seg++) begin
                case ($urandom_range(3))
                    0: begin
                        // small rates, up to the full burst
                        src = RATE_W'($urandom_range(1, 16));
                        tgt = RATE_W'($urandom_range(1, 64));
                    end
                    1: begin
                        // wide rates with a modest upsampling ratio
                        tgt = RATE_W'($urandom_range(1, 65535));
                        src = RATE_W'(tgt / $urandom_range(1, 8));
                        if (src == '0) begin
                            src = 16'd1;
                        end
                    end
                    2: begin
                        src = RATE_W'($urandom_range(1, 65535));
                        tgt = RATE_W'($urandom_range(1, 65535));
                    end
                    default: begin
                        src = $urandom_range(1) ? 16'hFFFF : 16'd1;
                        tgt = $urandom_range(1) ? 16'hFFFF : 16'd1;
                    end
                endcase
                apply_rates(src, tgt);
                repeat (SEG_ITEMS) send_sample(pick_sample());
            end
        end

        drain();
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("pcm_linear_resampler test passed");
        end else begin
            $display("pcm_linear_resampler test failed");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #200_000_000;
        $display("pcm_linear_resampler test failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/plr_pkg.sv
rtl/plr_in_if.sv
rtl/plr_out_if.sv
rtl/plr_divider.sv
rtl/pcm_linear_resampler.sv
rtl/plr_checker.sv
tb/plr_resample_checker.sv
tb/tb_top.sv
